[hdl/spq_pkg.sv]
// types and codes shared by the sorted priority queue
package spq_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] patient_id;
        logic [7:0]  prio;
        logic [15:0] treat;
        logic [3:0]  rank;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_id;
        logic [7:0]  out_prio;
        logic [15:0] out_treat;
        logic [4:0]  occupancy;
    } rsp_word_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] treat;
    } entry_t;

    typedef struct packed {
        logic   ins;
        logic   del;
        entry_t key;
    } cell_ctrl_t;

endpackage

[hdl/spq_cell.sv]
// one slot of the sorted chain: holds an entry and shifts left or right
module spq_cell
    import spq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
)
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] fill,
    input  entry_t           left_entry,
    input  logic             left_flag,
    input  entry_t           right_entry,
    input  logic             found_in,
    output entry_t           entry,
    output logic             flag,
    output logic             found_out
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occ;
    logic   goes_before;
    logic   match;

    assign occ         = CNT_W'(IDX) < fill;
    assign goes_before = (entry_reg.prio > ctrl.key.prio) ||
                         ((entry_reg.prio == ctrl.key.prio) &&
                          (entry_reg.treat >= ctrl.key.treat));
    assign flag        = !occ || goes_before;
    assign match       = occ && (entry_reg.id == ctrl.key.id);
    assign found_out   = found_in || match;
    assign entry       = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (left_flag)
            begin
                entry_next = left_entry;
            end
            else if (flag)
            begin
                entry_next = ctrl.key;
            end
        end
        else if (ctrl.del && found_out)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[hdl/sorted_priority_queue.sv]
// sorted priority queue built as a chain of shifting slots
//
//  channel | signals                     | direction | carries
//  req     | req_valid, req_stall, req   | in        | action and entry fields
//  rsp     | rsp_valid, rsp_stall, rsp   | out       | status, entry read, occupancy
//
//  a word is accepted into a command register, executed across all slots once
//  rsp can take a result, and its result lands in the output register; one
//  word per cycle while rsp is not stalled
//  rst_n clears the fill count and valid flags, slot contents stay as they are
//  a stalled rsp holds the command register, which then stalls req
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int RD_N  = (CAPACITY < 16) ? CAPACITY : 16;

    req_word_t        cmd_reg;
    logic             cmd_valid_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    rsp_word_t        rsp_reg;
    rsp_word_t        rsp_next;
    logic             rsp_valid_reg;
    logic             advance;
    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic             found;
    logic             rank_ok;
    cell_ctrl_t       ctrl;
    entry_t           rd_entry;

    entry_t           cell_entry [CAPACITY];
    logic             cell_flag  [CAPACITY];
    logic             cell_found [CAPACITY];

    assign advance   = cmd_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = cmd_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign is_full  = fill_reg >= CNT_W'(CAPACITY);
    assign is_empty = fill_reg == '0;
    assign found    = cell_found[CAPACITY-1];
    assign rank_ok  = CMP_W'(cmd_reg.rank) < CMP_W'(fill_reg);

    // a slot only shifts on delete once a match is seen at or before it
    always_comb
    begin
        ctrl.key.id    = cmd_reg.patient_id;
        ctrl.key.prio  = cmd_reg.prio;
        ctrl.key.treat = cmd_reg.treat;
        ctrl.ins = advance && (cmd_reg.action == ACT_INSERT) && !is_full;
        ctrl.del = advance && (cmd_reg.action == ACT_DELETE) && !is_empty;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_f;
            logic   found_i;
            if (g == 0)
            begin : g_head
                assign left_e  = cell_entry[g];
                assign left_f  = 1'b0;
                assign found_i = 1'b0;
            end
            else
            begin : g_body
                assign left_e  = cell_entry[g-1];
                assign left_f  = cell_flag[g-1];
                assign found_i = cell_found[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_tail
                assign right_e = cell_entry[g];
            end
            else
            begin : g_mid
                assign right_e = cell_entry[g+1];
            end
            spq_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .fill        (fill_reg),
                .left_entry  (left_e),
                .left_flag   (left_f),
                .right_entry (right_e),
                .found_in    (found_i),
                .entry       (cell_entry[g]),
                .flag        (cell_flag[g]),
                .found_out   (cell_found[g])
            );
        end
    endgenerate

    // rank only spans the first sixteen slots
    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (cmd_reg.rank == 4'(i))
            begin
                rd_entry = cell_entry[i];
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        rsp_next  = '0;
        case (cmd_reg.action)
            ACT_INSERT:
            begin
                if (is_full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    rsp_next.status = ST_OK;
                    fill_next       = fill_reg + 1'b1;
                end
            end
            ACT_DELETE:
            begin
                if (is_empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else if (!found)
                begin
                    rsp_next.status = ST_NOTFOUND;
                end
                else
                begin
                    rsp_next.status = ST_OK;
                    fill_next       = fill_reg - 1'b1;
                end
            end
            ACT_READ:
            begin
                if (rank_ok)
                begin
                    rsp_next.status    = ST_OK;
                    rsp_next.out_id    = rd_entry.id;
                    rsp_next.out_prio  = rd_entry.prio;
                    rsp_next.out_treat = rd_entry.treat;
                end
                else
                begin
                    rsp_next.status = ST_EMPTY;
                end
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
        rsp_next.occupancy = 5'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            fill_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                cmd_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                fill_reg      <= fill_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cmd_reg.action == ACT_INSERT) && is_full) |=> $stable(fill_reg))
        else $error("refused insert changed the fill count");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid)
        else $error("executed command gave no response");

    a_no_lost_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && !advance) |=> cmd_valid_reg)
        else $error("pending command dropped");

endmodule

[bench/tb_top.sv]
// testbench for the sorted priority queue: directed table, then random words against a predictor
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam int CAPACITY = 16;
    localparam int RANDOM_WORDS = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS = 2_000_000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        req_word_t cmd;
        bit        typed;
        rsp_word_t want;
    } directed_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid;
    logic      req_stall;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp;

    entry_t        queue_slots [CAPACITY];
    int            queue_fill = 0;
    int            insert_share = 55;
    rsp_word_t     awaited_rsp_q [$];
    directed_row_t plan [$];
    int            fail_count = 0;

    sorted_priority_queue #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL sorted_priority_queue");
        $finish;
    end

    function automatic rsp_word_t apply_to_queue(req_word_t cmd);
        rsp_word_t r;
        int        pos;
        int        i;
        r = '0;
        r.status = ST_OK;
        case (cmd.action)
            ACT_INSERT:
            begin
                if (queue_fill >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < queue_fill
                           && !(queue_slots[pos].prio > cmd.prio
                                || (queue_slots[pos].prio == cmd.prio
                                    && queue_slots[pos].treat >= cmd.treat)))
                        pos++;
                    for (i = queue_fill; i > pos; i--)
                        queue_slots[i] = queue_slots[i - 1];
                    queue_slots[pos] = {cmd.patient_id, cmd.prio, cmd.treat};
                    queue_fill++;
                end
            end
            ACT_DELETE:
            begin
                if (queue_fill == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    pos = 0;
                    while (pos < queue_fill && queue_slots[pos].id != cmd.patient_id)
                        pos++;
                    if (pos >= queue_fill)
                    begin
                        r.status = ST_NOTFOUND;
                    end
                    else
                    begin
                        for (i = pos; i + 1 < queue_fill; i++)
                            queue_slots[i] = queue_slots[i + 1];
                        queue_fill--;
                    end
                end
            end
            ACT_READ:
            begin
                if (int'(cmd.rank) >= queue_fill)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.out_id = queue_slots[cmd.rank].id;
                    r.out_prio = queue_slots[cmd.rank].prio;
                    r.out_treat = queue_slots[cmd.rank].treat;
                end
            end
            default:
            begin
                r.status = ST_OK;
            end
        endcase
        r.occupancy = 5'(queue_fill);
        return r;
    endfunction

    function automatic req_word_t pick_command();
        req_word_t c;
        int        roll;
        c.patient_id = 16'($urandom);
        c.prio = 8'($urandom);
        c.treat = 16'($urandom);
        c.rank = 4'($urandom);
        // narrow keys so that ties show up often
        if ($urandom_range(0, 2) == 0)
        begin
            c.prio = 8'($urandom_range(0, 3));
            c.treat = 16'($urandom_range(0, 3));
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            c.action = ACT_UNUSED;
        end
        else if (roll < insert_share)
        begin
            c.action = ACT_INSERT;
            if (queue_fill > 0 && $urandom_range(0, 9) == 0)
                c.patient_id = queue_slots[$urandom_range(0, queue_fill - 1)].id;
        end
        else if (roll < insert_share + (100 - insert_share) / 2)
        begin
            c.action = ACT_DELETE;
            if (queue_fill > 0 && $urandom_range(0, 3) != 0)
                c.patient_id = queue_slots[$urandom_range(0, queue_fill - 1)].id;
        end
        else
        begin
            c.action = ACT_READ;
            if (queue_fill > 0 && $urandom_range(0, 3) != 0)
                c.rank = 4'($urandom_range(0, queue_fill - 1));
        end
        return c;
    endfunction

    function automatic directed_row_t make_row(logic [1:0] act, logic [15:0] id,
                                               logic [7:0] p, logic [15:0] t,
                                               logic [3:0] rk, bit typed,
                                               logic [1:0] st, logic [4:0] occ);
        directed_row_t row;
        row.cmd = '{action: act, patient_id: id, prio: p, treat: t, rank: rk};
        row.typed = typed;
        row.want = '0;
        row.want.status = st;
        row.want.occupancy = occ;
        return row;
    endfunction

    task automatic build_plan();
        plan.push_back(make_row(ACT_READ,   16'h0000, 8'h00, 16'h0000, 4'd0, 1, ST_EMPTY, 5'd0));
        plan.push_back(make_row(ACT_DELETE, 16'h0000, 8'h00, 16'h0000, 4'd0, 1, ST_EMPTY, 5'd0));
        plan.push_back(make_row(ACT_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF, 4'hF, 1, ST_OK, 5'd0));
        plan.push_back(make_row(ACT_INSERT, 16'h1234, 8'h10, 16'h0010, 4'd0, 1, ST_OK, 5'd1));
        plan.push_back(make_row(ACT_DELETE, 16'h1234, 8'h00, 16'h0000, 4'd0, 1, ST_OK, 5'd0));
        plan.push_back(make_row(ACT_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF, 4'd0, 1, ST_OK, 5'd1));
        plan.push_back(make_row(ACT_INSERT, 16'h0000, 8'h00, 16'h0000, 4'd0, 1, ST_OK, 5'd2));
        plan.push_back(make_row(ACT_INSERT, 16'h0100, 8'h00, 16'hFFFF, 4'd0, 1, ST_OK, 5'd3));
        plan.push_back(make_row(ACT_INSERT, 16'h0101, 8'hFF, 16'h0000, 4'd0, 1, ST_OK, 5'd4));
        plan.push_back(make_row(ACT_INSERT, 16'h0102, 8'h80, 16'h8000, 4'd0, 1, ST_OK, 5'd5));
        plan.push_back(make_row(ACT_INSERT, 16'h0103, 8'h80, 16'h8000, 4'd0, 1, ST_OK, 5'd6));
        plan.push_back(make_row(ACT_INSERT, 16'h0102, 8'h80, 16'h7FFF, 4'd0, 1, ST_OK, 5'd7));
        for (int k = 7; k < CAPACITY; k++)
            plan.push_back(make_row(ACT_INSERT, 16'(16'h0200 + k), 8'(8'h40 + k % 3),
                                    16'(16'hF000 - k * 16'h0100), 4'd0, 1, ST_OK, 5'(k + 1)));
        plan.push_back(make_row(ACT_INSERT, 16'hABCD, 8'h01, 16'h0001, 4'd0, 1, ST_FULL, 5'd16));
        plan.push_back(make_row(ACT_READ,   16'h0000, 8'h00, 16'h0000, 4'hF, 0, ST_OK, 5'd0));
        plan.push_back(make_row(ACT_READ,   16'h0000, 8'h00, 16'h0000, 4'd0, 0, ST_OK, 5'd0));
        plan.push_back(make_row(ACT_DELETE, 16'h0102, 8'h00, 16'h0000, 4'd0, 1, ST_OK, 5'd15));
        plan.push_back(make_row(ACT_DELETE, 16'hBEEF, 8'h00, 16'h0000, 4'd0, 1, ST_NOTFOUND,
                                5'd15));
        plan.push_back(make_row(ACT_READ,   16'h0000, 8'h00, 16'h0000, 4'hF, 1, ST_EMPTY, 5'd15));
    endtask

    initial
    begin : drive_requests
        req_word_t cmd;
        rsp_word_t want;
        int        total;
        int        gap;
        int        burst_left;
        req_valid = 1'b0;
        req = '0;
        build_plan();
        total = plan.size() + RANDOM_WORDS;
        burst_left = 0;
        do @(posedge clk); while (!rst_n);
        for (int n = 0; n < total; n++)
        begin
            if (n % 150 == 0)
                insert_share = ($urandom_range(0, 2) == 0) ? 20 :
                               ($urandom_range(0, 1) == 0) ? 55 : 85;
            cmd = (n < plan.size()) ? plan[n].cmd : pick_command();
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 30);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            req <= cmd;
            req_valid <= 1'b1;
            do @(posedge clk); while (req_stall);
            want = apply_to_queue(cmd);
            if (n < plan.size() && plan[n].typed)
                want = plan[n].want;
            awaited_rsp_q.push_back(want);
        end
        req_valid <= 1'b0;
        while (awaited_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS sorted_priority_queue");
        else
            $display("FAIL sorted_priority_queue");
        $finish;
    end

    initial
    begin : drive_rsp_stall
        int mode;
        int seg;
        int seg_count;
        rsp_stall = 1'b0;
        seg_count = 0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            seg = $urandom_range(10, 150);
            // long hold-offs so the queue backs up into req
            if (seg_count == 3 || seg_count == 20)
            begin
                mode = 3;
                seg = 100;
            end
            seg_count++;
            for (int i = 0; i < seg; i++)
            begin
                case (mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    2: rsp_stall <= ($urandom_range(0, 3) != 0);
                    default: rsp_stall <= 1'b1;
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_responses
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_rsp_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected word: got %p", rsp);
            end
            else
            begin
                want = awaited_rsp_q.pop_front();
                if (rsp.status !== want.status || rsp.out_id !== want.out_id
                    || rsp.out_prio !== want.out_prio || rsp.out_treat !== want.out_treat
                    || rsp.occupancy !== want.occupancy)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected %p got %p", want, rsp);
                end
            end
        end
    end

endmodule

[filelist.f]
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
bench/tb_top.sv
